// ===== rtl/core/md5_pkg.sv =====
package md5_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       carries_byte;
      logic       end_of_message;
   } md5_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } md5_rsp_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] step_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [3:0] s);
      logic [4:0] r;
      case (s)
         4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
         4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
         4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // message word used by step i
   function automatic logic [3:0] word_sel(input logic [5:0] i);
      logic [3:0] w;
      case (i[5:4])
         2'd0: w = i[3:0];
         2'd1: w = 4'(5 * i[3:0] + 1);
         2'd2: w = 4'(3 * i[3:0] + 5);
         default: w = 4'(7 * i[3:0]);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/md5_ram.sv =====
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/md5_round.sv =====
// One MD5 step per cycle while step_en is high; the message word arrives from the block RAM.
module md5_round
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] init_a,
   input  logic [31:0] init_b,
   input  logic [31:0] init_c,
   input  logic [31:0] init_d,
   input  logic        step_en,
   input  logic [5:0]  step_idx,
   input  logic [31:0] msg_word,
   output logic [31:0] a_out,
   output logic [31:0] b_out,
   output logic [31:0] c_out,
   output logic [31:0] d_out
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] f_val, sum, rot;
   logic [4:0]  amt;

   always_comb begin
      case (step_idx[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f_val + msg_word + step_const(step_idx);
      amt = rot_amount({step_idx[5:4], step_idx[1:0]});
      rot = (sum << amt) | (sum >> (6'd32 - {1'b0, amt}));
   end

   // load the working words, or advance them by one step
   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= init_a;
         b_ff <= init_b;
         c_ff <= init_c;
         d_ff <= init_d;
      end else if (step_en) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= rot + b_ff;
      end
   end

   assign a_out = a_ff;
   assign b_out = b_ff;
   assign c_out = c_ff;
   assign d_out = d_ff;

endmodule

// ===== rtl/core/md5_digest_unit.sv =====
// MD5 digest over a byte stream, one byte per transfer. Bytes are gathered in
// a 16-word block RAM with a read-modify-write per byte; the next byte is not
// taken until that merge is written. A full block runs 64 compression steps,
// one per cycle, each reading its message word from the same RAM. An end mark
// pads, may compress twice, then offers the four digest words, word 0 first;
// the unit then restarts for the next message.
module md5_digest_unit
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  md5_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output md5_rsp_type rsp_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RMW   = 4'd1;  // byte merge, RAM read pending
   localparam logic [3:0] ST_PAD   = 4'd2;  // merge 0x80, RAM read pending
   localparam logic [3:0] ST_ZERO  = 4'd3;  // clear words after pad
   localparam logic [3:0] ST_PRIME = 4'd4;  // first word read of compress
   localparam logic [3:0] ST_COMP  = 4'd5;
   localparam logic [3:0] ST_FOLD  = 4'd6;
   localparam logic [3:0] ST_LEN   = 4'd7;  // write bit count words, or compress first
   localparam logic [3:0] ST_OUT   = 4'd8;
   localparam logic [3:0] ST_END   = 4'd9;  // end mark queued after byte

   logic [3:0]  state_ff, state_in;
   logic [60:0] total_ff, total_in;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        final_ff, final_in;  // compress is the last of a message
   logic        again_ff, again_in;  // a length block follows
   logic [5:0]  step_ff, step_in;
   logic [3:0]  zw_ff, zw_in;
   logic [1:0]  oi_ff, oi_in;

   logic        wr_en;
   logic [3:0]  wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   logic [31:0] ra, rb, rc, rd;
   logic        load, step_en;
   logic [5:0]  pos;
   logic [4:0]  sh;
   logic [31:0] merged;
   logic [63:0] bits;

   md5_ram #(.WIDTH(32), .DEPTH(16)) u_block (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   md5_round u_round (
      .clock(clock), .load(load),
      .init_a(h_ff[0]), .init_b(h_ff[1]), .init_c(h_ff[2]), .init_d(h_ff[3]),
      .step_en(step_en), .step_idx(step_ff), .msg_word(rd_data),
      .a_out(ra), .b_out(rb), .c_out(rc), .d_out(rd)
   );

   assign pos = total_ff[5:0];
   assign sh  = {pos[1:0], 3'b000};
   assign bits = {total_ff, 3'b000};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = {h_ff[oi_ff][7:0], h_ff[oi_ff][15:8],
                                  h_ff[oi_ff][23:16], h_ff[oi_ff][31:24]};
   assign rsp_data.word_index = oi_ff;
   assign rsp_data.last_word = (oi_ff == 2'd3);

   always_comb begin
      // a byte at lane 0 starts a fresh word
      merged = (pos[1:0] == 2'd0) ? 32'h0 : rd_data;
      merged = (merged & ~(32'hff << sh)) | ({24'h0, byte_ff} << sh);
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      h_in     = h_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      final_in = final_ff;
      again_in = again_ff;
      step_in  = step_ff;
      zw_in    = zw_ff;
      oi_in    = oi_ff;
      wr_en    = 1'b0;
      wr_addr  = pos[5:2];
      wr_data  = merged;
      rd_addr  = pos[5:2];
      load     = 1'b0;
      step_en  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               end_in = req_data.end_of_message;
               if (req_data.carries_byte) begin
                  byte_in  = req_data.data_byte;
                  state_in = ST_RMW;
               end else if (req_data.end_of_message) begin
                  byte_in  = PAD_BYTE;
                  state_in = ST_PAD;
               end
            end
         end
         ST_RMW: begin
            wr_en    = 1'b1;
            total_in = total_ff + 61'd1;
            if (pos == 6'd63) begin
               final_in = 1'b0;
               again_in = 1'b0;
               state_in = ST_PRIME;
            end else begin
               state_in = end_ff ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            byte_in  = PAD_BYTE;
            state_in = ST_PAD;
         end
         ST_PAD: begin
            wr_en    = 1'b1;
            zw_in    = 4'(pos[5:2] + 4'd1);
            again_in = (pos >= 6'd56);
            state_in = (pos[5:2] == 4'd15) ? ST_LEN : ST_ZERO;
         end
         ST_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = zw_ff;
            wr_data = 32'h0;
            zw_in   = zw_ff + 4'd1;
            if (zw_ff == 4'd15) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            // word 14 first while zw is not 15, then word 15; or compress first
            if (again_ff) begin
               final_in = 1'b0;
               state_in = ST_PRIME;
            end else begin
               wr_en   = 1'b1;
               wr_addr = (zw_ff == 4'd15) ? 4'd15 : 4'd14;
               wr_data = (zw_ff == 4'd15) ? bits[63:32] : bits[31:0];
               zw_in   = 4'd15;
               if (zw_ff == 4'd15) begin
                  final_in = 1'b1;
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            load     = 1'b1;
            rd_addr  = word_sel(6'd0);
            step_in  = 6'd0;
            state_in = ST_COMP;
         end
         ST_COMP: begin
            step_en = 1'b1;
            rd_addr = word_sel(6'(step_ff + 6'd1));
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + ra;
            h_in[1] = h_ff[1] + rb;
            h_in[2] = h_ff[2] + rc;
            h_in[3] = h_ff[3] + rd;
            if (final_ff) begin
               oi_in    = 2'd0;
               state_in = ST_OUT;
            end else if (again_ff) begin
               // second block: zeros then length
               again_in = 1'b0;
               zw_in    = 4'd0;
               state_in = ST_ZERO;
            end else begin
               state_in = end_ff ? ST_END : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oi_in = oi_ff + 2'd1;
               if (oi_ff == 2'd3) begin
                  h_in[0]  = INIT_A;
                  h_in[1]  = INIT_B;
                  h_in[2]  = INIT_C;
                  h_in[3]  = INIT_D;
                  total_in = '0;
                  end_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         h_ff[0]  <= INIT_A;
         h_ff[1]  <= INIT_B;
         h_ff[2]  <= INIT_C;
         h_ff[3]  <= INIT_D;
         end_ff   <= 1'b0;
         final_ff <= 1'b0;
         again_ff <= 1'b0;
         step_ff  <= '0;
         zw_ff    <= '0;
         oi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         h_ff     <= h_in;
         end_ff   <= end_in;
         final_ff <= final_in;
         again_ff <= again_in;
         step_ff  <= step_in;
         zw_ff    <= zw_in;
         oi_ff    <= oi_in;
      end
      byte_ff <= byte_in;
   end

   // digest words appear only after the last block of a message
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> final_ff)
      else $error("digest shown before final block");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && step_ff == 6'd63) |=> (state_ff == ST_FOLD))
      else $error("compress did not fold after 64 steps");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && oi_ff == 2'd3) |=> (state_ff == ST_IDLE))
      else $error("unit did not restart after digest");

endmodule
